@@ hdl/arpup_pkg.sv @@
// Package with the shared types and constants of the arpeggiator up-mode note selector.
`timescale 1ns / 1ps

package arpup_pkg;

  localparam int unsigned NOTE_COUNT_DEF = 128;
  localparam int unsigned NOTE_W         = 7;
  localparam int unsigned CMDQ_DEPTH     = 2;
  localparam int unsigned CMDQ_PTR_W     = 1;
  localparam int unsigned CMDQ_CNT_W     = 2;

  // Byte address of the mode register.
  localparam logic ARP_MODE_ADDR = 1'b0;

  typedef enum logic [1:0] {
    ACT_NOTE_ON  = 2'd0,
    ACT_NOTE_OFF = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_START    = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [NOTE_W-1:0] note;
    logic              clock_stop;
  } in_item_t;

  typedef struct packed {
    logic [NOTE_W-1:0] cv_note;
    logic              gate_high;
    logic              note_changed;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_SET   = 3'd0,
    CMD_CLR   = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_START = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e              kind;
    logic [NOTE_W-1:0] note;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } front_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EMIT = 2'd2
  } back_state_e;

endpackage

@@ hdl/arpup_front.sv @@
// Front end: accepts input transfers and turns them into commands for the back end.
`timescale 1ns / 1ps

module arpup_front #(
  parameter int unsigned NOTE_COUNT = arpup_pkg::NOTE_COUNT_DEF
) (
  input  logic                  in_valid_i,
  input  arpup_pkg::in_item_t   in_data_i,
  input  logic                  mode_i,
  input  arpup_pkg::q_status_t  q_status_i,
  output logic                  in_stall_o,
  output arpup_pkg::front_req_t req_o
);

  localparam int unsigned NoteExtW = arpup_pkg::NOTE_W + 1;

  logic accept;
  logic in_range;
  logic useful;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign in_range   = ({1'b0, in_data_i.note} < NoteExtW'(NOTE_COUNT));

  // Items that leave no trace (live-mode notes and ticks, notes out of range) are dropped here.
  always_comb begin
    useful           = 1'b0;
    req_o.cmd.kind   = arpup_pkg::CMD_STOP;
    req_o.cmd.note   = in_data_i.note;
    if (in_data_i.clock_stop) begin
      useful         = 1'b1;
      req_o.cmd.kind = arpup_pkg::CMD_STOP;
    end else begin
      unique case (in_data_i.action)
        arpup_pkg::ACT_START: begin
          useful         = 1'b1;
          req_o.cmd.kind = arpup_pkg::CMD_START;
        end
        arpup_pkg::ACT_NOTE_ON: begin
          useful         = mode_i && in_range;
          req_o.cmd.kind = arpup_pkg::CMD_SET;
        end
        arpup_pkg::ACT_NOTE_OFF: begin
          useful         = mode_i && in_range;
          req_o.cmd.kind = arpup_pkg::CMD_CLR;
        end
        arpup_pkg::ACT_TICK: begin
          useful         = mode_i;
          req_o.cmd.kind = arpup_pkg::CMD_TICK;
        end
        default: begin
          useful         = 1'b0;
          req_o.cmd.kind = arpup_pkg::CMD_STOP;
        end
      endcase
    end
    req_o.push = accept && useful;
  end

endmodule

@@ hdl/arpup_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module arpup_cmd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  arpup_pkg::front_req_t req_i,
  input  logic                  pop_i,
  output arpup_pkg::cmd_t       head_o,
  output arpup_pkg::q_status_t  status_o
);

  localparam int unsigned PtrW  = arpup_pkg::CMDQ_PTR_W;
  localparam int unsigned CntW  = arpup_pkg::CMDQ_CNT_W;
  localparam int unsigned Depth = arpup_pkg::CMDQ_DEPTH;

  arpup_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = req_i.push && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= req_i.cmd;
    end
  end

endmodule

@@ hdl/arpup_back.sv @@
// Back end: held-note set, upward scan sequencer and result register.
`timescale 1ns / 1ps

module arpup_back #(
  parameter int unsigned NOTE_COUNT = arpup_pkg::NOTE_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_clear_i,
  input  arpup_pkg::cmd_t      head_i,
  input  arpup_pkg::q_status_t q_status_i,
  output logic                 pop_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output arpup_pkg::out_item_t out_data_o
);

  localparam int unsigned IdxW  = $clog2(NOTE_COUNT);
  localparam int unsigned NoteW = arpup_pkg::NOTE_W;
  localparam int unsigned IncW  = NoteW + 1;

  arpup_pkg::back_state_e state_q, state_d;
  logic [NOTE_COUNT-1:0]  held_q, held_d;
  logic [NoteW-1:0]       last_q, last_d;
  logic                   has_last_q, has_last_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [IdxW-1:0]        cnt_q, cnt_d;
  arpup_pkg::out_item_t   res_q, res_d;
  logic                   out_valid_q, out_valid_d;
  arpup_pkg::out_item_t   out_data_q, out_data_d;

  logic            slot_free;
  logic            hit;
  logic            last_cnt;
  logic [IdxW-1:0] idx_next;
  logic [IncW-1:0] last_inc;
  logic [IdxW-1:0] start_idx;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign hit       = held_q[idx_q];
  assign last_cnt  = (cnt_q == IdxW'(NOTE_COUNT - 1));
  assign idx_next  = (idx_q == IdxW'(NOTE_COUNT - 1)) ? '0 : idx_q + IdxW'(1);
  assign last_inc  = {1'b0, last_q} + IncW'(1);

  always_comb begin
    if (!has_last_q || (last_inc == IncW'(NOTE_COUNT))) begin
      start_idx = '0;
    end else begin
      start_idx = last_inc[IdxW-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      arpup_pkg::ST_IDLE: begin
        if (!q_status_i.empty) begin
          if (head_i.kind == arpup_pkg::CMD_TICK) begin
            state_d = arpup_pkg::ST_SCAN;
          end else if (head_i.kind == arpup_pkg::CMD_STOP) begin
            state_d = arpup_pkg::ST_EMIT;
          end
        end
      end
      arpup_pkg::ST_SCAN: begin
        if (hit || last_cnt) begin
          state_d = arpup_pkg::ST_EMIT;
        end
      end
      arpup_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_d = arpup_pkg::ST_IDLE;
        end
      end
      default: state_d = arpup_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    pop_o       = 1'b0;
    held_d      = held_q;
    last_d      = last_q;
    has_last_d  = has_last_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      arpup_pkg::ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          unique case (head_i.kind)
            arpup_pkg::CMD_SET:   held_d[head_i.note[IdxW-1:0]] = 1'b1;
            arpup_pkg::CMD_CLR:   held_d[head_i.note[IdxW-1:0]] = 1'b0;
            arpup_pkg::CMD_START: has_last_d = 1'b0;
            arpup_pkg::CMD_TICK: begin
              idx_d = start_idx;
              cnt_d = '0;
            end
            arpup_pkg::CMD_STOP: begin
              res_d.cv_note      = last_q;
              res_d.gate_high    = 1'b0;
              res_d.note_changed = 1'b0;
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      arpup_pkg::ST_SCAN: begin
        if (hit) begin
          last_d             = NoteW'(idx_q);
          has_last_d         = 1'b1;
          res_d.cv_note      = NoteW'(idx_q);
          res_d.gate_high    = 1'b1;
          res_d.note_changed = 1'b1;
        end else if (last_cnt) begin
          // Nothing held: the pitch outputs keep the last note.
          has_last_d         = 1'b0;
          res_d.cv_note      = last_q;
          res_d.gate_high    = 1'b0;
          res_d.note_changed = 1'b0;
        end else begin
          idx_d = idx_next;
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      arpup_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
        end
      end
      default: pop_o = 1'b0;
    endcase

    if (cfg_clear_i) begin
      held_d     = '0;
      last_d     = '0;
      has_last_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arpup_pkg::ST_IDLE;
      held_q      <= '0;
      last_q      <= '0;
      has_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      last_q      <= last_d;
      has_last_q  <= has_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ hdl/arpeggiator_up_note_selector_unit.sv @@
// Top level of the arpeggiator up-mode note selector with its mode register port.
`timescale 1ns / 1ps

// Usage: MIDI events and clock events arrive on the input channel (in_valid_i, in_stall_o,
// in_data_i); one transfer carries an action, a note number and a clock-stop flag.
// Clock ticks in arpeggio mode and clock stops produce one result transfer each on the
// output channel (out_valid_o, out_stall_i, out_data_o); all other events only update
// the held-note set or the remembered last note.
// The front end classifies each transfer in the cycle it is accepted and places it in a
// two-entry command queue, so input is accepted one per cycle until the queue is full.
// The back end takes one command per cycle for note on, note off and clock start.
// A clock stop passes from the queue into the result register and then the output register.
// A tick scans the held set one note per cycle from the note after the last one played,
// and its result then takes the same path; this bit-serial scan sets the rate.
// Results sit in an output register; while the receiver stalls, the back end waits
// with its next result and the queue keeps accepting until it fills.
// Reset clears the held set, the last note, the mode register and all valid flags.
// The mode register is written over the APB-style port; any write to it also clears
// the held set and the last note.

module arpeggiator_up_note_selector_unit #(
  parameter int unsigned NOTE_COUNT = arpup_pkg::NOTE_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  arpup_pkg::in_item_t  in_data_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output arpup_pkg::out_item_t out_data_o,

  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned NoteExtW = arpup_pkg::NOTE_W + 1;

  logic                  mode_q, mode_d;
  logic                  cfg_write;
  logic                  addr_hit;
  arpup_pkg::front_req_t front_req;
  arpup_pkg::q_status_t  q_status;
  arpup_pkg::cmd_t       q_head;
  logic                  back_pop;

  // The port never inserts wait states. A write lands in the access cycle.
  assign pready    = 1'b1;
  assign addr_hit  = (paddr == arpup_pkg::ARP_MODE_ADDR);
  assign cfg_write = psel && penable && pwrite && pready && addr_hit;
  assign prdata    = addr_hit ? 32'(mode_q) : '0;
  assign mode_d    = cfg_write ? pwdata[0] : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  // The front end drops events that have no effect in the current mode.
  arpup_front #(
    .NOTE_COUNT(NOTE_COUNT)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .mode_i     (mode_q),
    .q_status_i (q_status),
    .in_stall_o (in_stall_o),
    .req_o      (front_req)
  );

  arpup_cmd_fifo u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (front_req),
    .pop_i    (back_pop),
    .head_o   (q_head),
    .status_o (q_status)
  );

  // The back end owns the held set and performs the scans.
  arpup_back #(
    .NOTE_COUNT(NOTE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_clear_i (cfg_write),
    .head_i      (q_head),
    .q_status_i  (q_status),
    .pop_o       (back_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // The queue can never claim to be full and empty at once.
  a_queue_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("command queue reports full and empty together");

  // The back end only removes commands that are really present.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_pop |-> !q_status.empty)
    else $error("back end popped an empty command queue");

  // A newly selected note always retriggers the gate and lies inside the scanned range.
  a_changed_note_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.note_changed) |->
      (out_data_o.gate_high && ({1'b0, out_data_o.cv_note} < NoteExtW'(NOTE_COUNT))))
    else $error("selected note result is inconsistent");
`endif

endmodule

@@ tb/sv/arpeggiator_up_note_selector_unit_tb.sv @@
// Self-checking testbench for the arpeggiator up-mode note selector unit.
`timescale 1ns / 1ps

// The testbench sends MIDI and clock events over the input channel and checks every result
// transfer against an untimed model of the note selector kept inside this module. The
// model runs when an input transfer is accepted, and it queues the result that this
// transfer should cause. The monitor then compares each result transfer, field by field,
// with the oldest queued result.
// The sender works in bursts with random gaps, and the receiver stalls in changing
// patterns. In one phase the receiver holds off for a long stretch while the sender keeps
// going, so the command queue fills and the block stalls its input.
// The mode register is written only while the block is idle. Note on, note off and clock
// start cause no result, so before each write the testbench waits out the longest scan.
module arpeggiator_up_note_selector_unit_tb;

  localparam int unsigned NOTES          = arpup_pkg::NOTE_COUNT_DEF;
  localparam int unsigned NOTE_W         = arpup_pkg::NOTE_W;
  // A tick can scan the whole held set before its result shows, so the drain time
  // covers two full scans with some margin.
  localparam int unsigned DRAIN_CYCLES   = 2 * NOTES + 16;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic        MODE_LIVE      = 1'b0;
  localparam logic        MODE_ARP       = 1'b1;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_pattern_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  arpup_pkg::in_item_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  arpup_pkg::out_item_t out_data;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic                 paddr     = 1'b0;
  logic [31:0]          pwdata    = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // State of the note selector as the testbench sees it.
  logic [NOTES-1:0]  held_notes  = '0;
  logic [NOTE_W-1:0] last_played = '0;
  logic              last_valid  = 1'b0;
  logic              arp_mode    = MODE_LIVE;

  arpup_pkg::in_item_t  pending_events[$];
  arpup_pkg::out_item_t expected_outputs[$];
  int unsigned          mismatch_count = 0;

  // Sender pacing.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  bit          no_gaps    = 1'b0;

  // Receiver pacing.
  stall_pattern_e stall_pattern = STALL_NONE;
  int unsigned    pattern_left  = 0;
  int unsigned    hold_left     = 0;
  bit             hold_request  = 1'b0;

  int unsigned quiet_cycles = 0;

  arpeggiator_up_note_selector_unit #(
    .NOTE_COUNT (NOTES)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Applies one accepted event to the model and queues the result it causes, if any.
  function automatic void note_sel_predict(input arpup_pkg::in_item_t ev);
    arpup_pkg::out_item_t res;
    int unsigned          first;
    int unsigned          cand;
    bit                   found;
    res   = '0;
    found = 1'b0;
    if (ev.clock_stop) begin
      // A clock stop overrides the action and drops the gate in either mode.
      res.cv_note = last_played;
      expected_outputs.push_back(res);
    end else if (ev.action == arpup_pkg::ACT_START) begin
      // Clock start forgets the last note, in live mode too.
      last_valid = 1'b0;
    end else if (arp_mode == MODE_ARP) begin
      case (ev.action)
        arpup_pkg::ACT_NOTE_ON: begin
          if (ev.note < NOTES) held_notes[ev.note] = 1'b1;
        end
        arpup_pkg::ACT_NOTE_OFF: begin
          if (ev.note < NOTES) held_notes[ev.note] = 1'b0;
        end
        default: begin
          // Upward scan with wrap, starting after the last note played.
          first = last_valid ? (last_played + 1) % NOTES : 0;
          for (int unsigned k = 0; k < NOTES && !found; k++) begin
            cand = (first + k) % NOTES;
            if (held_notes[cand]) begin
              found       = 1'b1;
              last_played = cand[NOTE_W-1:0];
            end
          end
          // With nothing held, the gate drops and the last note is forgotten, while
          // the pitch outputs keep their value.
          last_valid       = found;
          res.cv_note      = last_played;
          res.gate_high    = found;
          res.note_changed = found;
          expected_outputs.push_back(res);
        end
      endcase
    end
  endfunction

  // Sender: takes events from the pending queue in bursts separated by random gaps.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) note_sel_predict(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 && !no_gaps) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_events.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            // Mostly short gaps; now and then a long one, so that gaps fall on every
            // part of a scan.
            case ($urandom_range(0, 9))
              0, 1, 2: gap_left = 0;
              9:       gap_left = $urandom_range(20, 150);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls on a pattern that changes every so often, and on request holds off
  // for a long stretch.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall    <= 1'b0;
      pattern_left = 0;
      hold_left    = 0;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (pattern_left == 0) begin
        stall_pattern = stall_pattern_e'($urandom_range(0, 3));
        pattern_left  = $urandom_range(10, 200);
      end else begin
        pattern_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_pattern)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Monitor: every result transfer must match the oldest queued result.
  always @(posedge clk) begin : result_check
    arpup_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outputs.size() == 0) begin
        report_mismatch($sformatf("result with none expected: note %0d gate %0b changed %0b",
                                  out_data.cv_note, out_data.gate_high,
                                  out_data.note_changed));
      end else begin
        want = expected_outputs.pop_front();
        if (out_data.cv_note !== want.cv_note)
          report_mismatch($sformatf("cv_note %0d, expected %0d",
                                    out_data.cv_note, want.cv_note));
        if (out_data.gate_high !== want.gate_high)
          report_mismatch($sformatf("gate_high %0b, expected %0b",
                                    out_data.gate_high, want.gate_high));
        if (out_data.note_changed !== want.note_changed)
          report_mismatch($sformatf("note_changed %0b, expected %0b",
                                    out_data.note_changed, want.note_changed));
      end
    end
  end

  // Watchdog: ends the run when nothing moves on any port for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic push_event(input arpup_pkg::action_e act, input int unsigned note,
                            input bit stop);
    arpup_pkg::in_item_t ev;
    ev.action     = act;
    ev.note       = note[NOTE_W-1:0];
    ev.clock_stop = stop;
    pending_events.push_back(ev);
  endtask

  // Waits until every event is sent and every result has arrived, then lets the longest
  // scan run out, since the last events may cause no result.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_outputs.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the mode register with a setup and an access cycle. The write also clears the
  // held set and the last note.
  task automatic write_mode(input logic mode);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= arpup_pkg::ARP_MODE_ADDR;
    pwdata  <= {31'b0, mode};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    arp_mode    = mode;
    held_notes  = '0;
    last_played = '0;
    last_valid  = 1'b0;
  endtask

  task automatic start_phase(input logic mode);
    wait_idle();
    write_mode(mode);
    @(negedge clk);
  endtask

  // Random events. Most note offs release a note that this phase turned on, so that the
  // held set grows and shrinks and the scan meets both full and empty sets. Notes come
  // from the whole range or from a narrow cluster.
  task automatic run_random(input int unsigned count);
    arpup_pkg::in_item_t ev;
    logic [NOTE_W-1:0]   on_notes[$];
    int unsigned         pick;
    int unsigned         idx;
    int unsigned         base;
    base = $urandom_range(0, NOTES - 16);
    for (int unsigned j = 0; j < count; j++) begin
      ev      = '0;
      ev.note = NOTE_W'($urandom_range(0, NOTES - 1));
      pick    = $urandom_range(0, 99);
      if (pick < 5) begin
        ev.action     = arpup_pkg::action_e'($urandom_range(0, 3));
        ev.clock_stop = 1'b1;
      end else if (pick < 10) begin
        ev.action = arpup_pkg::ACT_START;
      end else if (pick < 45) begin
        ev.action = arpup_pkg::ACT_TICK;
      end else if (pick < 75) begin
        ev.action = arpup_pkg::ACT_NOTE_ON;
        if ($urandom_range(0, 1) == 0) ev.note = NOTE_W'(base + $urandom_range(0, 15));
        on_notes.push_back(ev.note);
      end else begin
        ev.action = arpup_pkg::ACT_NOTE_OFF;
        if (on_notes.size() != 0 && $urandom_range(0, 4) != 0) begin
          idx     = $urandom_range(0, on_notes.size() - 1);
          ev.note = on_notes[idx];
          on_notes.delete(idx);
        end
      end
      pending_events.push_back(ev);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part in arpeggio mode: empty set, the extreme notes, wrap of the scan,
    // clock start and stop, and a tick that finds the set emptied.
    write_mode(MODE_ARP);
    @(negedge clk);
    push_event(arpup_pkg::ACT_TICK, 0, 1'b0);       // nothing held yet
    push_event(arpup_pkg::ACT_NOTE_ON, 127, 1'b1);  // the stop flag overrides the note on
    push_event(arpup_pkg::ACT_NOTE_ON, 0, 1'b0);
    push_event(arpup_pkg::ACT_NOTE_ON, 127, 1'b0);
    push_event(arpup_pkg::ACT_NOTE_ON, 64, 1'b0);
    push_event(arpup_pkg::ACT_TICK, 0, 1'b0);
    push_event(arpup_pkg::ACT_TICK, 0, 1'b0);
    push_event(arpup_pkg::ACT_TICK, 0, 1'b0);
    push_event(arpup_pkg::ACT_TICK, 0, 1'b0);       // wraps from the top note back to the bottom
    push_event(arpup_pkg::ACT_START, 127, 1'b0);
    push_event(arpup_pkg::ACT_TICK, 127, 1'b0);     // after a start the scan begins at note zero
    push_event(arpup_pkg::ACT_NOTE_OFF, 0, 1'b0);
    push_event(arpup_pkg::ACT_TICK, 0, 1'b0);
    push_event(arpup_pkg::ACT_TICK, 0, 1'b1);       // clock stop keeps the last note
    push_event(arpup_pkg::ACT_TICK, 0, 1'b0);
    push_event(arpup_pkg::ACT_NOTE_OFF, 127, 1'b0);
    push_event(arpup_pkg::ACT_NOTE_OFF, 64, 1'b0);
    push_event(arpup_pkg::ACT_NOTE_OFF, 5, 1'b0);   // release of a note that is not held
    push_event(arpup_pkg::ACT_TICK, 0, 1'b0);       // set is empty again, the gate drops
    push_event(arpup_pkg::ACT_NOTE_ON, 85, 1'b0);
    push_event(arpup_pkg::ACT_NOTE_ON, 42, 1'b0);
    push_event(arpup_pkg::ACT_TICK, 0, 1'b0);
    push_event(arpup_pkg::ACT_START, 0, 1'b1);

    // Live mode: the write clears the notes still held; events other than a stop or a
    // start are ignored.
    start_phase(MODE_LIVE);
    push_event(arpup_pkg::ACT_NOTE_ON, 10, 1'b0);
    push_event(arpup_pkg::ACT_TICK, 0, 1'b0);
    push_event(arpup_pkg::ACT_START, 0, 1'b0);
    push_event(arpup_pkg::ACT_NOTE_OFF, 10, 1'b1);

    // Back in arpeggio mode the set must start empty.
    start_phase(MODE_ARP);
    push_event(arpup_pkg::ACT_TICK, 0, 1'b0);
    run_random(120);

    // Long hold of the receiver while the sender streams ticks without gaps.
    start_phase(MODE_ARP);
    no_gaps      = 1'b1;
    hold_request = 1'b1;
    for (int unsigned j = 0; j < 6; j++) begin
      push_event(arpup_pkg::ACT_NOTE_ON, $urandom_range(0, 127), 1'b0);
    end
    for (int unsigned j = 0; j < 40; j++) begin
      if ($urandom_range(0, 7) == 0) push_event(arpup_pkg::ACT_TICK, $urandom_range(0, 127), 1'b1);
      else push_event(arpup_pkg::ACT_TICK, $urandom_range(0, 127), 1'b0);
    end
    wait_idle();
    no_gaps = 1'b0;

    start_phase(MODE_LIVE);
    run_random(60);
    start_phase(MODE_ARP);
    run_random(130);
    start_phase(MODE_ARP);
    run_random(130);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
